// ----- sv/uvt_pkg.sv -----
`default_nettype none

package uvt_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_INVALID  = 3'd3,
        ST_CONTROL  = 3'd4
    } uvt_status_t;

    // one classified byte as it travels from the front to the back
    typedef struct packed {
        logic [6:0] lead_bits;
        logic [5:0] cont_bits;
        logic [2:0] lead_size;
        logic       is_cont;
        logic       has_byte;
        logic       is_last;
    } uvt_item_t;

    localparam int unsigned MID_DEPTH = 4;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd255;
    localparam logic [16:0] BYTE_SAT         = 17'h1FFFF;
    localparam logic [15:0] POINT_SAT        = 16'hFFFF;
    localparam logic [20:0] SURR_LO          = 21'h00D800;
    localparam logic [20:0] SURR_HI          = 21'h00DFFF;
    localparam logic [20:0] CP_MAX           = 21'h10FFFF;
    localparam logic [20:0] CTRL_LIMIT       = 21'h000020;
    localparam logic [20:0] DEL_CHAR         = 21'h00007F;

    // smallest value that a sequence of the given size may encode
    function automatic logic [20:0] min_value(input logic [2:0] size);
        logic [20:0] v;
        case (size)
            3'd2:    v = 21'h000080;
            3'd3:    v = 21'h000800;
            3'd4:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/uvt_front.sv -----
`default_nettype none

module uvt_front (
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          data_byte,
    input  wire logic                has_byte,
    input  wire logic                is_last,
    output logic                     q_push,
    output uvt_pkg::uvt_item_t       q_item,
    input  wire logic                q_full
);
    import uvt_pkg::*;

    logic [2:0] lead_size;

    always_comb
    begin
        if (data_byte inside {[8'h00:8'h7F]})
        begin
            lead_size = 3'd1;
        end
        else if (data_byte inside {[8'hC0:8'hDF]})
        begin
            lead_size = 3'd2;
        end
        else if (data_byte inside {[8'hE0:8'hEF]})
        begin
            lead_size = 3'd3;
        end
        else if (data_byte inside {[8'hF0:8'hF7]})
        begin
            lead_size = 3'd4;
        end
        else
        begin
            lead_size = 3'd0;
        end
    end

    always_comb
    begin
        q_item           = '0;
        q_item.lead_size = lead_size;
        q_item.is_cont   = (data_byte[7:6] == 2'b10);
        q_item.cont_bits = data_byte[5:0];
        q_item.has_byte  = has_byte;
        q_item.is_last   = is_last;
        case (lead_size)
            3'd1:    q_item.lead_bits = data_byte[6:0];
            3'd2:    q_item.lead_bits = {2'b00, data_byte[4:0]};
            3'd3:    q_item.lead_bits = {3'b000, data_byte[3:0]};
            3'd4:    q_item.lead_bits = {4'b0000, data_byte[2:0]};
            default: q_item.lead_bits = 7'd0;
        endcase
    end

    assign full = q_full;

    // items with neither a byte nor an end mark change nothing, drop them here
    assign q_push = push && !q_full && (has_byte || is_last);

endmodule

`default_nettype wire

// ----- sv/uvt_queue.sv -----
`default_nettype none

module uvt_queue #(
    parameter int unsigned Depth = uvt_pkg::MID_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire uvt_pkg::uvt_item_t  wr_item,
    output logic                     full,
    input  wire logic                rd_en,
    output uvt_pkg::uvt_item_t       rd_item,
    output logic                     valid,
    output logic [$clog2(Depth+1)-1:0] level
);
    import uvt_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_LEVEL = CW'(Depth);

    uvt_item_t     mem [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == FULL_LEVEL);
    assign valid = (count_reg != '0);
    assign level = count_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/uvt_back.sv -----
`default_nettype none

module uvt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [15:0]         max_length,
    input  wire logic                q_valid,
    input  wire uvt_pkg::uvt_item_t  q_item,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output logic [2:0]               status,
    output logic [15:0]              point_count
);
    import uvt_pkg::*;

    logic [16:0]  byte_total_reg, byte_total_next;
    logic [15:0]  point_total_reg, point_total_next;
    logic [1:0]   need_reg, need_next;
    logic [2:0]   seq_size_reg, seq_size_next;
    logic [20:0]  partial_reg, partial_next;
    uvt_status_t  error_reg, error_next;

    logic         res_valid_reg, res_valid_next;
    uvt_status_t  res_status_reg, res_status_next;
    logic [15:0]  res_count_reg, res_count_next;

    logic         consume;
    logic         fin;
    logic [20:0]  fin_val;
    logic [2:0]   fin_size;
    logic [20:0]  shifted;

    // a final item may only go when the result slot is free or frees now
    assign consume = q_valid && (!q_item.is_last || !res_valid_reg || pop);
    assign q_pop   = consume;
    assign shifted = {partial_reg[14:0], q_item.cont_bits};

    always_comb
    begin
        byte_total_next  = byte_total_reg;
        point_total_next = point_total_reg;
        need_next        = need_reg;
        seq_size_next    = seq_size_reg;
        partial_next     = partial_reg;
        error_next       = error_reg;
        res_valid_next   = res_valid_reg && !pop;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        fin              = 1'b0;
        fin_val          = '0;
        fin_size         = 3'd1;

        if (consume && q_item.has_byte)
        begin
            if (byte_total_reg != BYTE_SAT)
            begin
                byte_total_next = byte_total_reg + 1'b1;
            end
            if (error_reg == ST_OK)
            begin
                if (need_reg == 2'd0)
                begin
                    case (q_item.lead_size)
                        3'd0:
                        begin
                            error_next = ST_INVALID;
                        end
                        3'd1:
                        begin
                            fin     = 1'b1;
                            fin_val = {14'd0, q_item.lead_bits};
                        end
                        default:
                        begin
                            seq_size_next = q_item.lead_size;
                            partial_next  = {14'd0, q_item.lead_bits};
                            need_next     = 2'(q_item.lead_size - 3'd1);
                        end
                    endcase
                end
                else if (!q_item.is_cont)
                begin
                    error_next = ST_INVALID;
                end
                else
                begin
                    partial_next = shifted;
                    need_next    = need_reg - 2'd1;
                    if (need_reg == 2'd1)
                    begin
                        fin      = 1'b1;
                        fin_val  = shifted;
                        fin_size = seq_size_reg;
                    end
                end
            end
        end

        if (fin)
        begin
            if (fin_val < min_value(fin_size) || fin_val > CP_MAX ||
                (fin_val >= SURR_LO && fin_val <= SURR_HI))
            begin
                error_next = ST_INVALID;
            end
            else if (fin_val < CTRL_LIMIT || fin_val == DEL_CHAR)
            begin
                error_next = ST_CONTROL;
            end
            else if (point_total_reg != POINT_SAT)
            begin
                point_total_next = point_total_reg + 1'b1;
            end
        end

        if (consume && q_item.is_last)
        begin
            res_valid_next = 1'b1;
            res_count_next = '0;
            if (byte_total_next == '0)
            begin
                res_status_next = ST_EMPTY;
            end
            else if (byte_total_next > {1'b0, max_length})
            begin
                res_status_next = ST_TOO_LONG;
            end
            else if (error_next != ST_OK)
            begin
                res_status_next = error_next;
            end
            else if (need_next != 2'd0)
            begin
                res_status_next = ST_INVALID;
            end
            else
            begin
                res_status_next = ST_OK;
                res_count_next  = point_total_next;
            end
            byte_total_next  = '0;
            point_total_next = '0;
            need_next        = '0;
            seq_size_next    = '0;
            partial_next     = '0;
            error_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg  <= '0;
            point_total_reg <= '0;
            need_reg        <= '0;
            seq_size_reg    <= '0;
            partial_reg     <= '0;
            error_reg       <= ST_OK;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_total_reg  <= byte_total_next;
            point_total_reg <= point_total_next;
            need_reg        <= need_next;
            seq_size_reg    <= seq_size_next;
            partial_reg     <= partial_next;
            error_reg       <= error_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    assign empty       = !res_valid_reg;
    assign status      = res_status_reg;
    assign point_count = res_count_reg;

endmodule

`default_nettype wire

// ----- sv/utf8_display_text_validator.sv -----
// path: a final item is registered in the mid queue, then decoded by the back end into the result slot
// throughput: one item per cycle, set by the back end decode, while no final item waits on the result slot
// the mid queue absorbs stalls of the result side; a final item waits only for the result slot
// reset: asynchronous, clears decode state, mid queue and result slot; max_length back to 255
`default_nettype none

module utf8_display_text_validator #(
    parameter int unsigned MidDepth = uvt_pkg::MID_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       status,
    output logic [15:0]      point_count,
    input  wire logic        cfg_write,
    input  wire logic [15:0] cfg_data
);
    import uvt_pkg::*;

    localparam int unsigned CW = $clog2(MidDepth + 1);

    logic [15:0]   max_length_reg;
    logic          q_push, q_full, q_valid, q_pop;
    uvt_item_t     q_wr_item, q_rd_item;
    logic [CW-1:0] q_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            max_length_reg <= cfg_data;
        end
    end

    uvt_front u_front (
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .q_push    (q_push),
        .q_item    (q_wr_item),
        .q_full    (q_full)
    );

    uvt_queue #(
        .Depth (MidDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .valid   (q_valid),
        .level   (q_level)
    );

    uvt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_length  (max_length_reg),
        .q_valid     (q_valid),
        .q_item      (q_rd_item),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .point_count (point_count)
    );

    // a count only travels with an accepted text
    a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (point_count == 16'd0))
        else $error("nonzero count with error status");

    // queue level never passes its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= CW'(MidDepth))
        else $error("mid queue level out of range");

    // a final item never leaves the queue while an untaken result sits in the slot
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_rd_item.is_last && !empty) |-> pop)
        else $error("result slot overwritten");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import uvt_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       present;
        logic       ends_text;
    } text_item_t;

    typedef struct {
        uvt_status_t status_code;
        logic [15:0] points;
    } text_result_t;

    typedef enum int {
        POP_ALWAYS,
        POP_RANDOM,
        POP_PERIODIC,
        POP_SPARSE
    } pop_mode_t;

    localparam logic [16:0] TEXT_LEN_SAT  = 17'h1FFFF;
    localparam logic [15:0] GLYPH_SAT     = 16'hFFFF;
    localparam logic [20:0] UNI_TOP       = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST    = 21'h00D800;
    localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
    localparam logic [20:0] PRINT_FIRST   = 21'h000020;
    localparam logic [20:0] DEL_CODE      = 21'h00007F;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          QUIET_LIMIT   = 5000;
    localparam int          LONG_HOLD     = 400;
    localparam int          PHASE_ITEMS   = 120;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic [15:0] point_count;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = 16'h0000;

    text_item_t   pending_items[$];
    text_result_t expected_results[$];
    logic [7:0]   text_bytes[$];
    int           queued_bytes = 0;
    int           fail_count = 0;

    // predictor state
    logic [15:0]  limit_len = MAX_LENGTH_RESET;
    logic [16:0]  text_len = '0;
    logic [15:0]  glyph_count = '0;
    logic [1:0]   cont_left = '0;
    logic [2:0]   seq_len = '0;
    logic [20:0]  acc_value = '0;
    uvt_status_t  latched_err = ST_OK;

    // sender state
    int burst_left = 1;
    int gap_left = 0;

    // receiver state
    pop_mode_t    stall_mode = POP_ALWAYS;
    int           mode_left = 0;
    int           pop_tick = 0;
    int           hold_left = 0;
    logic         hold_ask = 1'b0;
    logic         hold_seen = 1'b0;
    text_result_t want;

    int quiet_cycles = 0;

    utf8_display_text_validator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .point_count (point_count),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_point(input logic [20:0] v, input logic [2:0] n);
        logic [20:0] lowest;
        case (n)
            3'd2:    lowest = 21'h000080;
            3'd3:    lowest = 21'h000800;
            3'd4:    lowest = 21'h010000;
            default: lowest = 21'h000000;
        endcase
        if (v < lowest || v > UNI_TOP || (v >= SURR_FIRST && v <= SURR_LAST))
            latched_err = ST_INVALID;
        else if (v < PRINT_FIRST || v == DEL_CODE)
            latched_err = ST_CONTROL;
        else if (glyph_count != GLYPH_SAT)
            glyph_count = glyph_count + 16'd1;
    endfunction

    function automatic void take_text_byte(input logic [7:0] b);
        if (text_len != TEXT_LEN_SAT)
            text_len = text_len + 17'd1;
        // after the first error only the length keeps counting
        if (latched_err != ST_OK)
            return;
        if (cont_left == 2'd0)
        begin
            if (b[7] == 1'b0)
                close_point({14'd0, b[6:0]}, 3'd1);
            else if (b[7:5] == 3'b110)
            begin
                seq_len = 3'd2;
                acc_value = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_len = 3'd3;
                acc_value = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_len = 3'd4;
                acc_value = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
            else
                latched_err = ST_INVALID;
        end
        else if (b[7:6] != 2'b10)
            latched_err = ST_INVALID;
        else
        begin
            acc_value = {acc_value[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
                close_point(acc_value, seq_len);
        end
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic present,
                                         input logic ends_text);
        text_result_t res;
        if (present)
            take_text_byte(b);
        if (ends_text)
        begin
            res.points = '0;
            if (text_len == 17'd0)
                res.status_code = ST_EMPTY;
            else if (text_len > {1'b0, limit_len})
                res.status_code = ST_TOO_LONG;
            else if (latched_err != ST_OK)
                res.status_code = latched_err;
            else if (cont_left != 2'd0)
                res.status_code = ST_INVALID;
            else
            begin
                res.status_code = ST_OK;
                res.points = glyph_count;
            end
            expected_results.push_back(res);
            text_len = '0;
            glyph_count = '0;
            cont_left = '0;
            seq_len = '0;
            acc_value = '0;
            latched_err = ST_OK;
        end
    endfunction

    // sampled on the same edge the dut sees, before any drive update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                limit_len = cfg_data;
            if (push && !full)
                predict_item(data_byte, has_byte, is_last);
        end
    end

    // sender: bursts of transfers separated by gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                pending_items.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                             : $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (push && full)
            begin
                // offered item stays on the port until taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pending_items.size() == 0)
                push <= 1'b0;
            else
            begin
                push <= 1'b1;
                data_byte <= pending_items[0].value;
                has_byte <= pending_items[0].present;
                is_last <= pending_items[0].ends_text;
            end
        end
    end

    // receiver: checks each transfer and stalls on its own pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, status %0d count %0d",
                             $time, status, point_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status_code)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status_code, status);
                        fail_count++;
                    end
                    if (point_count !== want.points)
                    begin
                        $display("%0t: point_count mismatch, expected %0d, actual %0d",
                                 $time, want.points, point_count);
                        fail_count++;
                    end
                end
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                stall_mode = pop_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            pop_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    POP_ALWAYS:   pop <= ($urandom_range(0, 9) < 10);
                    POP_RANDOM:   pop <= ($urandom_range(0, 9) < 6);
                    POP_PERIODIC: pop <= ((pop_tick % 5) < 2);
                    default:      pop <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("utf8_display_text_validator verification failed");
                $finish;
            end
        end
    end

    // checked away from the rising edge so the sender and predictor have both settled
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // queues text_bytes as one text, with stray ignored items mixed in
    task automatic push_text(input bit marker_end);
        text_item_t it;
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                it.value = 8'($urandom_range(0, 255));
                it.present = 1'b0;
                it.ends_text = 1'b0;
                pending_items.push_back(it);
            end
            it.value = text_bytes[i];
            it.present = 1'b1;
            it.ends_text = !marker_end && (i == text_bytes.size() - 1);
            pending_items.push_back(it);
            queued_bytes++;
        end
        if (marker_end || text_bytes.size() == 0)
        begin
            it.value = 8'($urandom_range(0, 255));
            it.present = 1'b0;
            it.ends_text = 1'b1;
            pending_items.push_back(it);
            queued_bytes++;
        end
    endtask

    function automatic int natural_size(input logic [20:0] v);
        if (v < 21'h80)
            return 1;
        else if (v < 21'h800)
            return 2;
        else if (v < 21'h10000)
            return 3;
        return 4;
    endfunction

    task automatic encode_point(input logic [20:0] v, input int n);
        case (n)
            1: text_bytes.push_back({1'b0, v[6:0]});
            2:
            begin
                text_bytes.push_back({3'b110, v[10:6]});
                text_bytes.push_back({2'b10, v[5:0]});
            end
            3:
            begin
                text_bytes.push_back({4'b1110, v[15:12]});
                text_bytes.push_back({2'b10, v[11:6]});
                text_bytes.push_back({2'b10, v[5:0]});
            end
            default:
            begin
                text_bytes.push_back({5'b11110, v[20:18]});
                text_bytes.push_back({2'b10, v[17:12]});
                text_bytes.push_back({2'b10, v[11:6]});
                text_bytes.push_back({2'b10, v[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] pick_point();
        logic [20:0] v;
        case ($urandom_range(0, 39))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15:
                v = 21'($urandom_range(32, 126));
            16, 17, 18, 19, 20, 21, 22, 23: v = 21'($urandom_range(21'h80, 21'h7FF));
            24, 25, 26, 27, 28, 29:         v = 21'($urandom_range(21'h800, 21'hFFFF));
            30, 31, 32, 33:                 v = 21'($urandom_range(21'h10000, UNI_TOP));
            34, 35:
            begin
                case ($urandom_range(0, 11))
                    0:       v = 21'h80;
                    1:       v = 21'h7FF;
                    2:       v = 21'h800;
                    3:       v = 21'hFFFF;
                    4:       v = SURR_FIRST - 21'd1;
                    5:       v = SURR_LAST + 21'd1;
                    6:       v = 21'h10000;
                    7:       v = UNI_TOP;
                    8:       v = UNI_TOP + 21'd1;
                    9:       v = PRINT_FIRST;
                    10:      v = DEL_CODE - 21'd1;
                    default: v = 21'h1FFFFF;
                endcase
            end
            36:      v = 21'($urandom_range(0, 31));
            37:      v = 21'($urandom_range(SURR_FIRST, SURR_LAST));
            38:      v = 21'($urandom_range(UNI_TOP + 21'd1, 21'h1FFFFF));
            default: v = DEL_CODE;
        endcase
        return v;
    endfunction

    // mostly well-formed texts, some raw noise and some damaged sequences
    task automatic add_random_text();
        logic [20:0] v;
        logic [7:0]  junk;
        int          n;
        int          points;
        int          kind;
        int          pos;
        text_bytes.delete();
        kind = $urandom_range(0, 9);
        points = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (kind == 7)
        begin
            repeat (points + 1)
            begin
                junk = 8'($urandom_range(0, 255));
                text_bytes.push_back(junk);
            end
        end
        else
        begin
            repeat (points + ((kind > 7) ? 1 : 0))
            begin
                v = pick_point();
                n = natural_size(v);
                if (n < 4 && $urandom_range(0, 29) == 0)
                    n++;
                encode_point(v, n);
            end
            if (kind > 7)
            begin
                pos = $urandom_range(0, text_bytes.size() - 1);
                junk = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0:       text_bytes.delete(text_bytes.size() - 1);
                    1:       text_bytes[pos] = junk;
                    default: text_bytes.insert(pos, junk);
                endcase
            end
        end
        push_text($urandom_range(0, 6) == 0);
    endtask

    initial
    begin
        logic [15:0] phase_limits[9];
        int          start_count;
        text_item_t  idle_item;

        phase_limits = '{16'd2, 16'd65535, 16'd1, 16'd0, 16'd5, 16'd12, 16'd300, 16'd3, 16'd255};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed texts at the reset length limit
        @(negedge clk);
        idle_item.value = 8'hFF;
        idle_item.present = 1'b0;
        idle_item.ends_text = 1'b0;
        pending_items.push_back(idle_item);
        text_bytes.delete();
        push_text(1'b0);
        text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        push_text(1'b0);
        text_bytes = '{8'hED, 8'hA0, 8'h80};
        push_text(1'b0);
        text_bytes = '{8'hC1, 8'hBF};
        push_text(1'b0);
        text_bytes = '{8'h7F};
        push_text(1'b0);
        text_bytes = '{8'h00};
        push_text(1'b0);
        text_bytes = '{8'hFF};
        push_text(1'b0);
        text_bytes = '{8'hE2, 8'h41};
        push_text(1'b1);
        text_bytes = '{8'hC3};
        push_text(1'b1);
        text_bytes = '{8'h20, 8'h7E};
        push_text(1'b0);
        wait_idle();

        // too-long wins over any decode error
        write_max_length(16'd1);
        @(negedge clk);
        text_bytes = '{8'h41, 8'h42};
        push_text(1'b0);
        text_bytes = '{8'hFF, 8'hFE};
        push_text(1'b0);
        text_bytes = '{8'h41};
        push_text(1'b0);
        text_bytes = '{8'hC3, 8'hA9};
        push_text(1'b0);
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            if (p == 6)
                write_max_length(16'($urandom_range(6, 65534)));
            else
                write_max_length(phase_limits[p]);
            @(negedge clk);
            start_count = queued_bytes;
            while (queued_bytes - start_count < PHASE_ITEMS)
                add_random_text();
            // long result-side stall while the sender keeps offering
            if (p == 1 || p == 5)
            begin
                @(posedge clk);
                hold_ask <= ~hold_ask;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("utf8_display_text_validator verification clean");
        else
            $display("utf8_display_text_validator verification failed");
        $finish;
    end

endmodule
